// ===== rtl/core/hilbert_curve_converter_macros.svh =====
`ifndef HILBERT_CURVE_CONVERTER_MACROS_SVH
`define HILBERT_CURVE_CONVERTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define HCC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define HCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/hcc_pkg.sv =====
package hcc_pkg;

   // largest grid order the chain supports, one cell per bit level
   localparam int MAX_ORDER = 16;
   localparam int COORD_W   = MAX_ORDER;
   localparam int INDEX_W   = 2 * MAX_ORDER;
   localparam int ORDER_W   = 5;
   localparam int LEVEL_W   = $clog2(MAX_ORDER + 1);

   // conversion direction
   localparam logic ACT_TO_INDEX  = 1'b0;
   localparam logic ACT_TO_COORDS = 1'b1;

   typedef struct packed {
      logic               action;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [INDEX_W-1:0] curve_index;
   } hcc_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index_out;
      logic [COORD_W-1:0] x_out;
      logic [COORD_W-1:0] y_out;
   } hcc_rsp_type;

   // working word that walks down the chain
   typedef struct packed {
      logic               action;
      logic [ORDER_W-1:0] order;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [INDEX_W-1:0] index;
   } hcc_word_type;

   typedef struct packed {
      logic         valid;
      hcc_word_type word;
   } hcc_link_type;

endpackage

// ===== rtl/core/hcc_cell.sv =====
module hcc_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [hcc_pkg::LEVEL_W-1:0] cell_pos,
   input  hcc_pkg::hcc_link_type       in_link,
   output logic                        in_ready,
   output hcc_pkg::hcc_link_type       out_link,
   input  logic                        out_ready
);
   import hcc_pkg::*;

   logic               valid_ff;
   hcc_word_type       word_ff;
   hcc_word_type       word_in;
   logic [LEVEL_W-1:0] lvl;
   logic               active;
   logic               rx;
   logic               ry;
   logic [1:0]         pair;
   logic [COORD_W-1:0] lmask;
   logic [COORD_W-1:0] xt;
   logic [COORD_W-1:0] yt;

   // top-down levels for coords to index, bottom-up for index to coords
   assign lvl    = (in_link.word.action == ACT_TO_COORDS) ? cell_pos
                   : LEVEL_W'(MAX_ORDER - 1) - cell_pos;
   assign active = ORDER_W'(lvl) < in_link.word.order;
   assign pair   = 2'(in_link.word.index >> {lvl, 1'b0});
   assign lmask  = (COORD_W'(1) << lvl) - COORD_W'(1);

   // one level of rotate and flip
   always_comb begin
      word_in = in_link.word;
      xt      = in_link.word.x;
      yt      = in_link.word.y;
      rx      = 1'b0;
      ry      = 1'b0;
      if (in_link.word.action == ACT_TO_INDEX) begin
         rx = 1'((in_link.word.x >> lvl) & COORD_W'(1));
         ry = 1'((in_link.word.y >> lvl) & COORD_W'(1));
         if (active) begin
            word_in.index = in_link.word.index | (INDEX_W'({rx, rx ^ ry}) << {lvl, 1'b0});
            if (!ry) begin
               if (rx) begin
                  xt = ~xt;
                  yt = ~yt;
               end
               word_in.x = yt;
               word_in.y = xt;
            end
         end
      end else begin
         rx = pair[1];
         ry = pair[0] ^ pair[1];
         if (active) begin
            if (!ry) begin
               if (rx) begin
                  xt = xt ^ lmask;
                  yt = yt ^ lmask;
               end
               word_in.x = yt;
               word_in.y = xt;
            end
            word_in.x = word_in.x | (COORD_W'(rx) << lvl);
            word_in.y = word_in.y | (COORD_W'(ry) << lvl);
         end
      end
   end

   // stage advances when empty or the neighbor takes its word
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_link.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_link.valid) begin
         word_ff <= word_in;
      end
   end

   assign out_link.valid = valid_ff;
   assign out_link.word  = word_ff;

endmodule

// ===== rtl/core/hilbert_curve_converter.sv =====
// Hilbert curve converter: maps (x, y) to the distance along a Hilbert curve
// (action 0) or a distance back to (x, y) (action 1) on a grid of side
// 2**grid_order, orders above 16 saturating to 16. A row of 16 cells, one per
// bit level, is followed by an output register that every accepted word passes
// through in turn, and one word is accepted per cycle whenever the response
// side is not stalled. grid_order resets to 16 and is sampled as each word
// enters, so it must only change while the block is empty.
`include "hilbert_curve_converter_macros.svh"

module hilbert_curve_converter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  hcc_pkg::hcc_req_type        req_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output hcc_pkg::hcc_rsp_type        rsp_word,
   input  logic                        csr_write_enable,
   input  logic [hcc_pkg::ORDER_W-1:0] csr_write_data
);
   import hcc_pkg::*;

   logic [ORDER_W-1:0] grid_order_ff;
   logic [ORDER_W-1:0] eff_order;
   hcc_link_type       head_link;
   hcc_link_type       link [0:MAX_ORDER];
   logic               ready [0:MAX_ORDER];
   logic               rsp_valid_ff;
   hcc_rsp_type        rsp_word_ff;
   hcc_rsp_type        rsp_word_in;
   hcc_word_type       last_word;

   // order register
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_order_ff <= ORDER_W'(MAX_ORDER);
      end else if (csr_write_enable) begin
         grid_order_ff <= csr_write_data;
      end
   end

   assign eff_order = (grid_order_ff > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER)
                      : grid_order_ff;

   // incoming word into the chain
   always_comb begin
      head_link.valid       = req_valid;
      head_link.word.action = req_word.action;
      head_link.word.order  = eff_order;
      head_link.word.index  = '0;
      head_link.word.x      = '0;
      head_link.word.y      = '0;
      if (req_word.action == ACT_TO_INDEX) begin
         head_link.word.x = req_word.coord_x;
         head_link.word.y = req_word.coord_y;
      end else begin
         head_link.word.index = req_word.curve_index;
      end
   end

   assign link[0]   = head_link;
   assign req_stall = !ready[0];

   // one cell per bit level
   for (genvar i = 0; i < MAX_ORDER; i++) begin : g_cell
      hcc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_pos  (LEVEL_W'(i)),
         .in_link   (link[i]),
         .in_ready  (ready[i]),
         .out_link  (link[i+1]),
         .out_ready (ready[i+1])
      );
   end

   // output register, unused fields zeroed
   assign last_word = link[MAX_ORDER].word;

   always_comb begin
      rsp_word_in = '0;
      if (last_word.action == ACT_TO_INDEX) begin
         rsp_word_in.index_out = last_word.index;
      end else begin
         rsp_word_in.x_out = last_word.x;
         rsp_word_in.y_out = last_word.y;
      end
   end

   assign ready[MAX_ORDER] = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready[MAX_ORDER]) begin
         rsp_valid_ff <= link[MAX_ORDER].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[MAX_ORDER] && link[MAX_ORDER].valid) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a draining output never backs up the request side
   `HCC_ASSERT_IMPL(a_no_stall_when_drained, !rsp_stall, !req_stall, "request stalled while response drains")
   // an accepted word lands in the first cell
   `HCC_ASSERT_NEXT(a_first_cell_loaded, req_valid && !req_stall, link[1].valid, "accepted word lost at first cell")
   // only one direction's result fields may be nonzero
   `HCC_ASSERT_IMPL(a_one_side_zero, rsp_valid, (rsp_word.index_out == '0) || ((rsp_word.x_out == '0) && (rsp_word.y_out == '0)), "both index and coordinates set")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import hcc_pkg::*;

   // checks each result word against the oldest predicted conversion
   class curve_scoreboard;
      hcc_rsp_type awaited[$];
      int          errors;

      function new();
         errors = 0;
      endfunction

      // only the first ten are printed, the rest are just counted
      function void flag(string what);
         errors++;
         if (errors <= 10) begin
            $display("%s", what);
         end
      endfunction

      // hilbert walk at the effective order, orders above the max saturate
      function hcc_rsp_type predict_conversion(hcc_req_type w, logic [ORDER_W-1:0] order);
         int          eff;
         logic [63:0] cmask, x, y, d, t, s, rx, ry, q, tmp;
         hcc_rsp_type r;
         eff = (order > MAX_ORDER) ? MAX_ORDER : int'(order);
         r = '0;
         cmask = (64'd1 << eff) - 64'd1;
         if (w.action == ACT_TO_INDEX) begin
            // top level down, rotating and flipping the quadrant
            x = 64'(w.coord_x) & cmask;
            y = 64'(w.coord_y) & cmask;
            d = '0;
            for (int lvl = eff - 1; lvl >= 0; lvl--) begin
               rx = (x >> lvl) & 64'd1;
               ry = (y >> lvl) & 64'd1;
               q = ((64'd3 * rx) ^ ry) & 64'd3;
               d = d | (q << (2 * lvl));
               if (ry == 64'd0) begin
                  if (rx == 64'd1) begin
                     x = ~x & cmask;
                     y = ~y & cmask;
                  end
                  tmp = x;
                  x = y;
                  y = tmp;
               end
            end
            r.index_out = d[INDEX_W-1:0];
         end else begin
            // bottom level up
            t = 64'(w.curve_index) & ((64'd1 << (2 * eff)) - 64'd1);
            x = '0;
            y = '0;
            for (int lvl = 0; lvl < eff; lvl++) begin
               s = 64'd1 << lvl;
               rx = (t >> 1) & 64'd1;
               ry = (t ^ rx) & 64'd1;
               if (ry == 64'd0) begin
                  if (rx == 64'd1) begin
                     x = (s - 64'd1) - x;
                     y = (s - 64'd1) - y;
                  end
                  tmp = x;
                  x = y;
                  y = tmp;
               end
               x = x + (rx << lvl);
               y = y + (ry << lvl);
               t = t >> 2;
            end
            r.x_out = x[COORD_W-1:0];
            r.y_out = y[COORD_W-1:0];
         end
         return r;
      endfunction

      function void note_request(hcc_req_type w, logic [ORDER_W-1:0] order);
         awaited = {awaited, predict_conversion(w, order)};
      endfunction

      function void check_response(hcc_rsp_type got);
         hcc_rsp_type exp;
         if (awaited.size() == 0) begin
            flag($sformatf("unexpected result word idx=%h x=%h y=%h",
                           got.index_out, got.x_out, got.y_out));
            return;
         end
         exp = awaited.pop_front();
         if (got.index_out !== exp.index_out) begin
            flag($sformatf("index_out mismatch: expected %h, got %h",
                           exp.index_out, got.index_out));
         end
         if (got.x_out !== exp.x_out) begin
            flag($sformatf("x_out mismatch: expected %h, got %h", exp.x_out, got.x_out));
         end
         if (got.y_out !== exp.y_out) begin
            flag($sformatf("y_out mismatch: expected %h, got %h", exp.y_out, got.y_out));
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   hcc_req_type        req_word = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   hcc_rsp_type        rsp_word;
   logic               csr_write_enable = 1'b0;
   logic [ORDER_W-1:0] csr_write_data = '0;

   // testbench copy of the order register, reset value 16
   logic [ORDER_W-1:0] grid_order = 5'd16;
   bit                 quiet = 1'b0;
   curve_scoreboard    board = new();

   hilbert_curve_converter u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // present one word after a random gap and hold it until taken
   task automatic send_request(hcc_req_type w);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(w, grid_order);
   endtask

   // hold off until every result is back, then let the row empty
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_order(logic [ORDER_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      grid_order = value;
   endtask

   function automatic hcc_req_type make_request(logic action, logic [COORD_W-1:0] x,
                                                logic [COORD_W-1:0] y,
                                                logic [INDEX_W-1:0] idx);
      hcc_req_type w;
      w.action      = action;
      w.coord_x     = x;
      w.coord_y     = y;
      w.curve_index = idx;
      return w;
   endfunction

   // mostly full random words, some pinned to the grid corners or to small values
   function automatic hcc_req_type random_request();
      hcc_req_type w;
      w.action      = ($urandom_range(0, 1) != 0) ? ACT_TO_COORDS : ACT_TO_INDEX;
      w.coord_x     = COORD_W'($urandom);
      w.coord_y     = COORD_W'($urandom);
      w.curve_index = INDEX_W'($urandom);
      case ($urandom_range(0, 7))
         0: begin
            w.coord_x = ($urandom_range(0, 1) != 0) ? '1 : '0;
            w.coord_y = ($urandom_range(0, 1) != 0) ? '1 : '0;
         end
         1: begin
            w.curve_index = ($urandom_range(0, 1) != 0) ? '1 : '0;
         end
         2: begin
            w.coord_x     = COORD_W'($urandom_range(0, 7));
            w.coord_y     = COORD_W'($urandom_range(0, 7));
            w.curve_index = INDEX_W'($urandom_range(0, 63));
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic directed_corners();
      send_request(make_request(ACT_TO_INDEX, 16'h0000, 16'h0000, 32'h0));
      send_request(make_request(ACT_TO_INDEX, 16'hffff, 16'hffff, 32'h0));
      send_request(make_request(ACT_TO_INDEX, 16'hffff, 16'h0000, 32'hffffffff));
      send_request(make_request(ACT_TO_INDEX, 16'h0000, 16'hffff, 32'h12345678));
      send_request(make_request(ACT_TO_COORDS, 16'h0000, 16'h0000, 32'h00000000));
      send_request(make_request(ACT_TO_COORDS, 16'hffff, 16'hffff, 32'hffffffff));
      send_request(make_request(ACT_TO_COORDS, 16'ha5a5, 16'h5a5a, 32'h55555555));
      send_request(make_request(ACT_TO_COORDS, 16'h0000, 16'hffff, 32'haaaaaaaa));
   endtask

   // response side: random stall before each word
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = quiet ? 0 : $urandom_range(0, 3);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         board.check_response(rsp_word);
      end
   end

   // stimulus
   initial begin
      int orders[$];
      int waited;
      orders = '{1, 2, 16, 3, 0, 31, 5, 17, 8, 12, 4, 16, 24, 9, 1};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset order of 16, then single cell, saturated and smallest grids
      directed_corners();
      drain_pipeline();
      write_order(5'd0);
      directed_corners();
      drain_pipeline();
      write_order(5'd31);
      directed_corners();
      drain_pipeline();
      write_order(5'd1);
      send_request(make_request(ACT_TO_INDEX, 16'h0001, 16'h0000, 32'h0));
      send_request(make_request(ACT_TO_COORDS, 16'h0000, 16'h0000, 32'h00000002));

      // random phases, each at its own order
      for (int p = 0; p < orders.size() + 1; p++) begin
         drain_pipeline();
         quiet = (p % 4 == 3);
         if (p < orders.size()) begin
            write_order(ORDER_W'(orders[p]));
         end else begin
            write_order(ORDER_W'($urandom_range(0, 31)));
         end
         for (int i = 0; i < 80; i++) begin
            // a pause until all results are back, mid phase, in every third phase
            if (i == 40 && p % 3 == 1) begin
               drain_pipeline();
            end
            send_request(random_request());
         end
      end
      quiet = 1'b0;

      // let the last words come back, bounded
      req_valid <= 1'b0;
      waited = 0;
      while (board.awaited.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (board.awaited.size() != 0) begin
         board.flag($sformatf("%0d result words never arrived", board.awaited.size()));
      end

      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
